>>> hw/rtl/pgw_pkg.sv
// ----------------------------------------------------------------------------
// pgw_pkg: shared types and constants for the page table walker
// Queue command layout, field widths and the code values on both channels.
// ----------------------------------------------------------------------------
package pgw_pkg;

   localparam int VA_BITS     = 48;   // virtual address width
   localparam int PAGE_SHIFT  = 12;   // 4 KiB pages
   localparam int PN_BITS     = 64 - PAGE_SHIFT;  // page number of a 64-bit address
   localparam int IDX_BITS    = 9;    // table index per level
   localparam int ENTRY_SHIFT = 3;    // 8-byte entries
   localparam int QUEUE_DEPTH = 2;

   // req_type codes
   localparam logic REQ_TRANSLATE = 1'b0;
   localparam logic REQ_RESPONSE  = 1'b1;

   // rsp_result_kind codes
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // walk levels
   localparam logic [1:0] LEVEL_TOP  = 2'd0;
   localparam logic [1:0] LEVEL_L3   = 2'd1;
   localparam logic [1:0] LEVEL_L2   = 2'd2;
   localparam logic [1:0] LEVEL_LAST = 2'd3;

   // Classified transaction held in the front-to-back queue.
   // page: root page number for a request, masked entry base for a response.
   typedef struct packed {
      logic                is_resp;
      logic                read_ok;
      logic [PN_BITS-1:0]  page;
      logic [VA_BITS-1:0]  vaddr;
   } pgw_cmd_type;

endpackage

>>> hw/rtl/pgw_front.sv
// ----------------------------------------------------------------------------
// pgw_front: input acceptance and classification
// Takes request/response transactions, strips them down to a page number
// and writes them into the queue.
// ----------------------------------------------------------------------------
module pgw_front
   import pgw_pkg::*;
#(
   parameter int PHYS_ADDR_BITS = 40
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [63:0]           req_table_root,
   input  logic [VA_BITS-1:0]    req_virt_addr,
   input  logic [63:0]           req_entry_data,
   input  logic                  req_read_ok,
   input  logic                  q_full,
   output logic                  q_push,
   output pgw_cmd_type           q_cmd
);

   logic [PN_BITS-1:0] entry_page;

   // entry base: bits PHYS_ADDR_BITS-1..12, everything above is dropped
   assign entry_page = PN_BITS'(req_entry_data[PHYS_ADDR_BITS-1:PAGE_SHIFT]);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.is_resp = (req_type == REQ_RESPONSE);
      q_cmd.read_ok = req_read_ok;
      q_cmd.vaddr   = req_virt_addr;
      if (req_type == REQ_RESPONSE) begin
         q_cmd.page = entry_page;
      end else begin
         q_cmd.page = req_table_root[63:PAGE_SHIFT];
      end
   end

endmodule

>>> hw/rtl/pgw_queue.sv
// ----------------------------------------------------------------------------
// pgw_queue: short flop queue between front and back
// Lets the front keep accepting while the back waits on the result channel.
// ----------------------------------------------------------------------------
module pgw_queue
   import pgw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pgw_cmd_type  push_cmd,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output pgw_cmd_type  head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pgw_cmd_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff,  count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hw/rtl/pgw_back.sv
// ----------------------------------------------------------------------------
// pgw_back: walk sequencer and result register
// Holds the walk state, turns each queued transaction into a read request
// or a walk result, and drives the result channel from a register.
// ----------------------------------------------------------------------------
module pgw_back
   import pgw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_not_empty,
   input  pgw_cmd_type   q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_result_kind,
   output logic [63:0]   rsp_out_address,
   output logic          rsp_fault
);

   logic                busy_ff,  busy_in;
   logic [1:0]          level_ff, level_in;
   logic [VA_BITS-1:0]  vaddr_ff, vaddr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                kind_ff, kind_in;
   logic [63:0]         addr_ff, addr_in;
   logic                fault_ff, fault_in;

   logic                out_free;
   logic                emits;
   logic [IDX_BITS-1:0] next_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // a response while idle is dropped and needs no output slot
   assign emits    = !q_head.is_resp || busy_ff;
   assign q_pop    = q_not_empty && (out_free || !emits);

   // index for the level after the current one
   always_comb begin
      unique case (level_ff)
         LEVEL_TOP: next_idx = vaddr_ff[38:30];
         LEVEL_L3:  next_idx = vaddr_ff[29:21];
         default:   next_idx = vaddr_ff[20:12];
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      level_in     = level_ff;
      vaddr_in     = vaddr_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         priority if (!q_head.is_resp) begin
            busy_in      = 1'b1;
            level_in     = LEVEL_TOP;
            vaddr_in     = q_head.vaddr;
            rsp_valid_in = 1'b1;
            kind_in      = KIND_READ;
            fault_in     = 1'b0;
            addr_in      = {q_head.page, q_head.vaddr[47:39], {ENTRY_SHIFT{1'b0}}};
         end else if (!busy_ff) begin
            // dropped
         end else if (!q_head.read_ok) begin
            busy_in      = 1'b0;
            level_in     = LEVEL_TOP;
            rsp_valid_in = 1'b1;
            kind_in      = KIND_DONE;
            fault_in     = 1'b1;
            addr_in      = '0;
         end else if (level_ff == LEVEL_LAST) begin
            busy_in      = 1'b0;
            level_in     = LEVEL_TOP;
            rsp_valid_in = 1'b1;
            kind_in      = KIND_DONE;
            fault_in     = 1'b0;
            addr_in      = {q_head.page, vaddr_ff[PAGE_SHIFT-1:0]};
         end else begin
            level_in     = level_ff + 2'd1;
            rsp_valid_in = 1'b1;
            kind_in      = KIND_READ;
            fault_in     = 1'b0;
            addr_in      = {q_head.page, next_idx, {ENTRY_SHIFT{1'b0}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= LEVEL_TOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vaddr_ff <= vaddr_in;
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      fault_ff <= fault_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_address = addr_ff;
   assign rsp_fault       = fault_ff;

endmodule

>>> hw/rtl/four_level_page_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_walker: four-level page table walker, 48-bit VA, 4 KiB pages
// Turns translation requests and memory read responses into entry read
// requests and final physical addresses (or a fault).
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_stall  type, table_root, virt_addr,
//                                             entry_data, read_ok
//   rsp_*     out        rsp_valid/rsp_stall  result_kind, out_address, fault
//
// The back end takes one queued transaction at a time; sustained rate is one
// transaction per cycle while rsp_stall stays low. An accepted transaction
// goes into the queue at the accepting edge, then into the back end's result
// register, which drives rsp_valid. Reset (synchronous, active high) empties
// the queue, clears the result valid flag and leaves the walker idle at the
// top level. A stall on rsp_ holds the result register; the two-entry queue
// absorbs two more transactions before req_stall rises.
//
module four_level_page_walker
   import pgw_pkg::*;
#(
   parameter int PHYS_ADDR_BITS = 40   // 32 to 52
) (
   input  logic                clock,
   input  logic                reset,
   // request / read-response channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [63:0]         req_table_root,
   input  logic [VA_BITS-1:0]  req_virt_addr,
   input  logic [63:0]         req_entry_data,
   input  logic                req_read_ok,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [63:0]         rsp_out_address,
   output logic                rsp_fault
);

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_not_empty;
   pgw_cmd_type  q_cmd;
   pgw_cmd_type  q_head;

   // Front: accept and classify. Responses carry only the masked entry base,
   // requests the root page number.
   pgw_front #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_table_root (req_table_root),
      .req_virt_addr  (req_virt_addr),
      .req_entry_data (req_entry_data),
      .req_read_ok    (req_read_ok),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (q_cmd)
   );

   // Decoupling queue: keeps transaction order intact.
   pgw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // Back: walk state and result register. Entry addresses need no adder,
   // since the base is page aligned and 8 * index stays below 4096.
   pgw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_address (rsp_out_address),
      .rsp_fault       (rsp_fault)
   );

endmodule

>>> hw/rtl/pgw_checker.sv
// ----------------------------------------------------------------------------
// pgw_checker: port-level checks for the page table walker
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module pgw_checker
   import pgw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         rsp_result_kind,
   input  logic [63:0]  rsp_out_address,
   input  logic         rsp_fault
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_out_address) && $stable(rsp_fault))
      else $error("stalled result changed");

   // a fault ends the walk with a zero address
   a_fault_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_result_kind == KIND_DONE
         && rsp_out_address == 64'd0)
      else $error("fault with bad kind or address");

   // entry reads are 8-byte aligned and never fault
   a_read_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_READ |-> !rsp_fault
         && rsp_out_address[2:0] == 3'd0)
      else $error("misaligned or faulting entry read");

endmodule

bind four_level_page_walker pgw_checker u_pgw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_out_address (rsp_out_address),
   .rsp_fault       (rsp_fault)
);

>>> dv/tb_four_level_page_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_page_walker: self-checking bench for the page table walker
// Directed table of walks, faults and restarts, then random walks with bursty
// flow control on both channels, checked against a behavioral walker model.
// ----------------------------------------------------------------------------
module tb_four_level_page_walker;
   import pgw_pkg::*;

   localparam int          PA_BITS      = 40;
   localparam logic [63:0] PHYS_MASK    = (64'd1 << PA_BITS) - 64'd1;
   localparam logic [63:0] PAGE_MASK    = 64'hFFF;
   localparam int          WALK_ITEMS   = 1650;   // result-producing transactions
   localparam int          QUIET_ITEMS  = 150;    // tail of the run with no idling
   localparam int          HOLD_CYCLES  = 300;    // long receiver hold-off
   localparam int          DRAIN_CYCLES = 20;
   localparam int          MAX_REPORTS  = 10;
   localparam int          LIMIT_CYCLES = 500000;
   localparam int          NUM_DIRECTED = 24;

   // one transaction on the req_ channel
   typedef struct packed {
      logic                kind;
      logic [63:0]         root;
      logic [VA_BITS-1:0]  va;
      logic [63:0]         entry;
      logic                ok;
   } walk_req_type;

   // one transaction on the rsp_ channel
   typedef struct packed {
      logic         kind;
      logic [63:0]  addr;
      logic         fault;
   } walk_rsp_type;

   // directed row: typed rows carry a hand-written expectation
   typedef struct packed {
      logic          typed;
      walk_req_type  s;
      logic          has_out;
      walk_rsp_type  rsp;
   } dir_row_type;

   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      // response right after reset: walker is idle, dropped
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      // zero root, zero address
      '{1'b1, '{REQ_TRANSLATE, 64'h0, 48'h0, 64'h0, 1'b0},
        1'b1, '{KIND_READ, 64'h0, 1'b0}},
      // failed read at the top level
      '{1'b1, '{REQ_RESPONSE, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
        1'b1, '{KIND_DONE, 64'h0, 1'b1}},
      // failed response while idle: dropped as well
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0, 1'b0},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      // all-ones walk: max root, max address, max entries
      '{1'b1, '{REQ_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b0},
        1'b1, '{KIND_READ, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        1'b1, '{KIND_READ, 64'h0000_00FF_FFFF_FFF8, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        1'b1, '{KIND_READ, 64'h0000_00FF_FFFF_FFF8, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        1'b1, '{KIND_READ, 64'h0000_00FF_FFFF_FFF8, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        1'b1, '{KIND_DONE, 64'h0000_00FF_FFFF_FFFF, 1'b0}},
      // restart mid-walk
      '{1'b0, '{REQ_TRANSLATE, 64'h0000_0012_3456_7ABC, 48'h1234_5678_9ABC, 64'h0, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b0, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h8000_00AB_CDEF_1FFF, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b0, '{REQ_TRANSLATE, 64'hFFF0_0000_0000_0000, 48'h8000_0000_0000, 64'h0, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b0, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0000_0001_0000_0000, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      // fault one level down
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0000_0001_0000_0000, 1'b0},
        1'b1, '{KIND_DONE, 64'h0, 1'b1}},
      // alternating patterns, fault two levels down
      '{1'b0, '{REQ_TRANSLATE, 64'h5555_5555_5555_5000, 48'hAAAA_AAAA_AAAA, 64'h0, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b0, '{REQ_RESPONSE, 64'h0, 48'h0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b0, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h5555_5555_5555_5555, 1'b1},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h5555_5555_5555_5555, 1'b0},
        1'b1, '{KIND_DONE, 64'h0, 1'b1}},
      // zero tables, fault at the last level
      '{1'b0, '{REQ_TRANSLATE, 64'h0, 48'h0000_0000_0FFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
        1'b0, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0, 1'b1},
        1'b1, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0, 1'b1},
        1'b1, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0, 1'b1},
        1'b1, '{KIND_READ, 64'h0, 1'b0}},
      '{1'b1, '{REQ_RESPONSE, 64'h0, 48'h0, 64'h0, 1'b0},
        1'b1, '{KIND_DONE, 64'h0, 1'b1}},
      // request with read_ok low: the flag means nothing on a request
      '{1'b0, '{REQ_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 64'h0, 1'b0},
        1'b0, '{KIND_READ, 64'h0, 1'b0}}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid;
   logic                req_stall;
   logic                req_type;
   logic [63:0]         req_table_root;
   logic [VA_BITS-1:0]  req_virt_addr;
   logic [63:0]         req_entry_data;
   logic                req_read_ok;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_result_kind;
   logic [63:0]         rsp_out_address;
   logic                rsp_fault;

   // expected rsp_ transactions, oldest first
   walk_rsp_type walk_results_q [$];

   // walker model state
   logic                walk_active = 1'b0;
   logic [1:0]          walk_depth  = LEVEL_TOP;
   logic [VA_BITS-1:0]  walk_va     = '0;

   int   error_count  = 0;
   int   result_items = 0;
   int   cycle_count  = 0;
   logic idle_on      = 1'b1;   // random idling on both sides
   logic hold_req     = 1'b0;   // asks the receiver for the long hold-off

   always #5 clock = ~clock;

   four_level_page_walker #(
      .PHYS_ADDR_BITS (PA_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_table_root  (req_table_root),
      .req_virt_addr   (req_virt_addr),
      .req_entry_data  (req_entry_data),
      .req_read_ok     (req_read_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_address (rsp_out_address),
      .rsp_fault       (rsp_fault)
   );

   // --------------------------------------------------------------------------
   // Walker model
   // --------------------------------------------------------------------------

   // Address of the 8-byte entry picked by the address slice of this level:
   // level 0 uses va[47:39], level 3 uses va[20:12].
   function automatic logic [63:0] table_slot(input logic [63:0] base, input logic [1:0] lvl,
                                              input logic [VA_BITS-1:0] va);
      logic [8:0] idx;
      idx = 9'((va >> (39 - 9 * int'(lvl))) & 48'h1FF);
      return base + (64'(idx) << ENTRY_SHIFT);
   endfunction

   // One accepted req_ transaction; has_out tells whether it yields a result.
   function automatic void walk_step(input walk_req_type s, output logic has_out,
                                     output walk_rsp_type r);
      logic [63:0] base;
      has_out = 1'b0;
      r       = '0;
      if (s.kind == REQ_TRANSLATE) begin
         // new walk, any walk in flight is abandoned
         walk_va     = s.va;
         walk_depth  = LEVEL_TOP;
         walk_active = 1'b1;
         has_out     = 1'b1;
         r           = '{KIND_READ, table_slot(s.root & ~PAGE_MASK, LEVEL_TOP, s.va), 1'b0};
      end else if (walk_active) begin
         has_out = 1'b1;
         if (!s.ok) begin
            walk_active = 1'b0;
            walk_depth  = LEVEL_TOP;
            r           = '{KIND_DONE, 64'd0, 1'b1};
         end else begin
            // present / large-page bits are not looked at, only the frame bits
            base = s.entry & PHYS_MASK & ~PAGE_MASK;
            if (walk_depth == LEVEL_LAST) begin
               walk_active = 1'b0;
               walk_depth  = LEVEL_TOP;
               r           = '{KIND_DONE, base + {52'd0, walk_va[11:0]}, 1'b0};
            end else begin
               walk_depth = walk_depth + 2'd1;
               r          = '{KIND_READ, table_slot(base, walk_depth, walk_va), 1'b0};
            end
         end
      end
      // else: response with no walk in flight, dropped
   endfunction

   // --------------------------------------------------------------------------
   // Random fields, biased toward the extremes now and then
   // --------------------------------------------------------------------------
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return 64'hFFFF_FFFF_FFFF_FFFF;
         1:       return 64'h0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic walk_req_type rand_request();
      return '{REQ_TRANSLATE, rand_word(), VA_BITS'(rand_word()), rand_word(),
               1'($urandom_range(0, 1))};
   endfunction

   function automatic walk_req_type rand_response(input logic ok);
      return '{REQ_RESPONSE, rand_word(), VA_BITS'(rand_word()), rand_word(), ok};
   endfunction

   // --------------------------------------------------------------------------
   // Sender: payload changes on the falling edge, acceptance is seen on the
   // rising edge. valid stays high from one transaction to the next unless an
   // idle burst is drawn in between.
   // --------------------------------------------------------------------------
   task automatic send_transaction(input walk_req_type s, input logic use_typed,
                                   input logic typed_out, input walk_rsp_type typed_rsp);
      logic         pred_out;
      walk_rsp_type pred;
      if (idle_on && !hold_req && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_type       = s.kind;
      req_table_root = s.root;
      req_virt_addr  = s.va;
      req_entry_data = s.entry;
      req_read_ok    = s.ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: advance the model
      walk_step(s, pred_out, pred);
      if (use_typed) begin
         pred_out = typed_out;
         pred     = typed_rsp;
      end
      if (pred_out) begin
         walk_results_q.push_back(pred);
         result_items++;
      end
      @(negedge clock);
   endtask

   // Mostly complete walks with random content; some cut short by a fault,
   // some abandoned by the next request, and a few stray responses.
   task automatic random_walk();
      int   choice;
      int   depth;
      logic ok;
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
         send_transaction(rand_response(1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
      end else begin
         send_transaction(rand_request(), 1'b0, 1'b0, '0);
         depth = (choice == 1) ? $urandom_range(0, 3) : 4;
         for (int lvl = 0; lvl < depth; lvl++) begin
            ok = ($urandom_range(0, 11) != 0);
            send_transaction(rand_response(ok), 1'b0, 1'b0, '0);
            if (!ok) break;
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // Receiver: stall in random bursts; one long hold-off when asked, so the
   // queue fills and req_stall rises while the sender keeps offering.
   // --------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result checker: every accepted rsp_ transaction against the oldest
   // expectation, field by field.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      walk_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (walk_results_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR %0t: unexpected result kind=%0d addr=%h fault=%0d",
                        $realtime, rsp_result_kind, rsp_out_address, rsp_fault);
         end else begin
            want = walk_results_q.pop_front();
            if (rsp_result_kind !== want.kind || rsp_out_address !== want.addr ||
                rsp_fault !== want.fault) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("ERROR %0t: kind %0d/%0d addr %h/%h fault %0d/%0d (exp/act)",
                           $realtime, want.kind, rsp_result_kind, want.addr,
                           rsp_out_address, want.fault, rsp_fault);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      req_valid      = 1'b0;
      req_type       = REQ_TRANSLATE;
      req_table_root = '0;
      req_virt_addr  = '0;
      req_entry_data = '0;
      req_read_ok    = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_transaction(DIRECTED[i].s, DIRECTED[i].typed, DIRECTED[i].has_out,
                          DIRECTED[i].rsp);

      // random walks; the long hold-off hits at the start of this phase
      hold_req = 1'b1;
      result_items = 0;
      while (result_items < WALK_ITEMS) begin
         if (result_items >= WALK_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
         random_walk();
      end
      req_valid = 1'b0;
      idle_on   = 1'b0;

      // drain, then a few more cycles to catch anything extra
      while (walk_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (walk_results_q.size() != 0) begin
         error_count += walk_results_q.size();
         $display("ERROR: %0d expected results never arrived", walk_results_q.size());
      end

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/pgw_pkg.sv
hw/rtl/pgw_front.sv
hw/rtl/pgw_queue.sv
hw/rtl/pgw_back.sv
hw/rtl/four_level_page_walker.sv
hw/rtl/pgw_checker.sv
dv/tb_four_level_page_walker.sv
